// ===== rtl/wbe_pkg.sv =====
// Shared types and constants for the waypoint bearing error core.
// Holds the pipeline word, field widths and the CORDIC arctangent table.
// No dependencies; every module of the core imports this package.
`timescale 1ns / 1ps
`default_nettype none

package wbe_pkg;

   localparam int POS_W       = 32;
   localparam int PROX_W      = 31;
   localparam int HEADING_W   = 16;
   localparam int DXY_W       = POS_W + 1;
   localparam int PRESCALE_SH = 26;
   localparam int CORDIC_W    = 63;
   localparam int ANGLE_W     = 32;
   localparam int MAX_STEPS   = 24;

   // Bearings used when dx is zero, 65536 per turn.
   localparam logic [HEADING_W-1:0] BEARING_DY_POS  = 16'hFFFF;
   localparam logic [HEADING_W-1:0] BEARING_DY_ZERO = 16'hC000;
   localparam logic [HEADING_W-1:0] BEARING_DY_NEG  = 16'h8000;

   localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;
   // Negate and round to 16 bits in one add: -z + 2^15 = ~z + 2^15 + 1.
   localparam logic [ANGLE_W-1:0] ROUND_NEG = 32'h0000_8001;

   localparam logic [ANGLE_W-1:0] ATAN_TURNS [MAX_STEPS] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
      32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
   };

   typedef struct packed {
      logic                        valid;
      logic signed [CORDIC_W-1:0]  x;
      logic signed [CORDIC_W-1:0]  y;
      logic        [ANGLE_W-1:0]   z;
      logic        [HEADING_W-1:0] heading;
      logic                        arrived;
      logic                        dx_zero;
      logic        [HEADING_W-1:0] bearing_fix;
   } cordic_type;

endpackage

`default_nettype wire

// ===== rtl/wbe_front.sv =====
// Front end of the bearing core: position differences, arrival test and
// the half-turn pre-rotation that seeds the CORDIC. Uses wbe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wbe_front
   import wbe_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   input  wire logic signed [POS_W-1:0]     robot_x,
   input  wire logic signed [POS_W-1:0]     robot_y,
   input  wire logic        [HEADING_W-1:0] robot_heading,
   input  wire logic signed [POS_W-1:0]     target_x,
   input  wire logic signed [POS_W-1:0]     target_y,
   input  wire logic        [PROX_W-1:0]    proximity,
   output cordic_type                       out_ff
);

   localparam int PAD_W = CORDIC_W - DXY_W - PRESCALE_SH;

   logic                 valid_ff;
   logic [DXY_W-1:0]     dx_ff, dx_in;
   logic [DXY_W-1:0]     dy_ff, dy_in;
   logic [HEADING_W-1:0] heading_ff;
   logic [PROX_W-1:0]    prox_ff;

   logic signed [DXY_W:0]      dx_w, dy_w, prox_w;
   logic                       arrived;
   logic signed [CORDIC_W-1:0] x_pre, y_pre;
   cordic_type                 out_in;

   assign dx_in = {target_x[POS_W-1], target_x} - {robot_x[POS_W-1], robot_x};
   assign dy_in = {target_y[POS_W-1], target_y} - {robot_y[POS_W-1], robot_y};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      heading_ff <= robot_heading;
      prox_ff    <= proximity;
   end

   // |d| < p is tested as -p < d < p, both compares side by side.
   always_comb begin
      dx_w    = $signed({dx_ff[DXY_W-1], dx_ff});
      dy_w    = $signed({dy_ff[DXY_W-1], dy_ff});
      prox_w  = $signed({{(DXY_W + 1 - PROX_W){1'b0}}, prox_ff});
      arrived = (dx_w < prox_w) && ((dx_w + prox_w) > 0) &&
                (dy_w < prox_w) && ((dy_w + prox_w) > 0);
      x_pre   = $signed({{PAD_W{dy_ff[DXY_W-1]}}, dy_ff, {PRESCALE_SH{1'b0}}});
      y_pre   = $signed({{PAD_W{dx_ff[DXY_W-1]}}, dx_ff, {PRESCALE_SH{1'b0}}});

      out_in.valid   = valid_ff;
      out_in.heading = heading_ff;
      out_in.arrived = arrived;
      out_in.dx_zero = (dx_ff == '0);
      if (!dy_ff[DXY_W-1] && (dy_ff != '0)) begin
         out_in.bearing_fix = BEARING_DY_POS;
      end else if (dy_ff == '0) begin
         out_in.bearing_fix = BEARING_DY_ZERO;
      end else begin
         out_in.bearing_fix = BEARING_DY_NEG;
      end
      // A vector in the lower half plane is turned by half a turn first.
      if (dy_ff[DXY_W-1]) begin
         out_in.x = -x_pre;
         out_in.y = -y_pre;
         out_in.z = HALF_TURN;
      end else begin
         out_in.x = x_pre;
         out_in.y = y_pre;
         out_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff.valid <= out_in.valid;
      end
      out_ff.x           <= out_in.x;
      out_ff.y           <= out_in.y;
      out_ff.z           <= out_in.z;
      out_ff.heading     <= out_in.heading;
      out_ff.arrived     <= out_in.arrived;
      out_ff.dx_zero     <= out_in.dx_zero;
      out_ff.bearing_fix <= out_in.bearing_fix;
   end

endmodule

`default_nettype wire

// ===== rtl/wbe_cordic_stage.sv =====
// One vectoring CORDIC iteration of the bearing core, registered.
// The iteration index sets the shift and the arctangent constant. Uses wbe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wbe_cordic_stage
   import wbe_pkg::*;
#(
   parameter int unsigned STEP = 0
)
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cordic_type in_data,
   output cordic_type     out_ff
);

   localparam logic [ANGLE_W-1:0] ATAN = ATAN_TURNS[STEP];

   logic signed [CORDIC_W-1:0] x_cur, y_cur, x_sh, y_sh;
   logic                       y_pos;
   cordic_type                 out_in;

   always_comb begin
      x_cur  = in_data.x;
      y_cur  = in_data.y;
      // Arithmetic shifts floor toward minus infinity.
      x_sh   = x_cur >>> STEP;
      y_sh   = y_cur >>> STEP;
      y_pos  = !y_cur[CORDIC_W-1] && (y_cur != '0);
      out_in = in_data;
      if (y_pos) begin
         out_in.x = x_cur + y_sh;
         out_in.y = y_cur - x_sh;
         out_in.z = in_data.z + ATAN;
      end else begin
         out_in.x = x_cur - y_sh;
         out_in.y = y_cur + x_sh;
         out_in.z = in_data.z - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff.valid <= out_in.valid;
      end
      out_ff.x           <= out_in.x;
      out_ff.y           <= out_in.y;
      out_ff.z           <= out_in.z;
      out_ff.heading     <= out_in.heading;
      out_ff.arrived     <= out_in.arrived;
      out_ff.dx_zero     <= out_in.dx_zero;
      out_ff.bearing_fix <= out_in.bearing_fix;
   end

endmodule

`default_nettype wire

// ===== rtl/wbe_back.sv =====
// Back end of the bearing core: negates and rounds the CORDIC angle to a
// 16-bit bearing, then subtracts the heading. Two register stages. Uses wbe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wbe_back
   import wbe_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cordic_type            in_data,
   output logic                       rsp_strobe,
   output logic       [HEADING_W-1:0] rsp_heading_error,
   output logic                       rsp_arrived
);

   logic                 valid_ff;
   logic [HEADING_W-1:0] bearing_ff, bearing_in;
   logic [HEADING_W-1:0] heading_ff;
   logic                 arrived_ff;
   logic [ANGLE_W-1:0]   rounded;

   logic                 strobe_ff;
   logic [HEADING_W-1:0] error_ff;
   logic                 arrived_out_ff;

   assign rounded    = ~in_data.z + ROUND_NEG;
   assign bearing_in = in_data.dx_zero ? in_data.bearing_fix
                                       : rounded[ANGLE_W-1 -: HEADING_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         valid_ff  <= in_data.valid;
         strobe_ff <= valid_ff;
      end
      bearing_ff     <= bearing_in;
      heading_ff     <= in_data.heading;
      arrived_ff     <= in_data.arrived;
      error_ff       <= bearing_ff - heading_ff;
      arrived_out_ff <= arrived_ff;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_heading_error = error_ff;
   assign rsp_arrived       = arrived_out_ff;

endmodule

`default_nettype wire

// ===== rtl/waypoint_bearing_error_core.sv =====
// Waypoint bearing error core. Every cycle it can take a pose and waypoint
// (start high transfers one); busy is always low, since the pipeline never
// stalls. Each result appears with rsp_strobe for exactly one cycle,
// once its request has passed two front stages for the position
// differences and pre-rotation, one stage per CORDIC iteration, and two back
// stages for rounding and the heading subtraction. The receiver must take
// every result in the cycle it is shown. Depends on wbe_pkg and its submodules.
`timescale 1ns / 1ps
`default_nettype none

module waypoint_bearing_error_core
   import wbe_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
)
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic signed [POS_W-1:0]     req_robot_x,
   input  wire logic signed [POS_W-1:0]     req_robot_y,
   input  wire logic        [HEADING_W-1:0] req_robot_heading,
   input  wire logic signed [POS_W-1:0]     req_target_x,
   input  wire logic signed [POS_W-1:0]     req_target_y,
   input  wire logic        [PROX_W-1:0]    req_proximity,
   output logic                             rsp_strobe,
   output logic             [HEADING_W-1:0] rsp_heading_error,
   output logic                             rsp_arrived
);

   cordic_type pipe [CORDIC_STEPS + 1];
   logic       req_transfer;

   assign busy         = 1'b0;
   assign req_transfer = start && !busy;

   wbe_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_transfer),
      .robot_x       (req_robot_x),
      .robot_y       (req_robot_y),
      .robot_heading (req_robot_heading),
      .target_x      (req_target_x),
      .target_y      (req_target_y),
      .proximity     (req_proximity),
      .out_ff        (pipe[0])
   );

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      wbe_cordic_stage #(
         .STEP (i)
      ) u_stage (
         .clock   (clock),
         .reset   (reset),
         .in_data (pipe[i]),
         .out_ff  (pipe[i+1])
      );
   end

   wbe_back u_back (
      .clock             (clock),
      .reset             (reset),
      .in_data           (pipe[CORDIC_STEPS]),
      .rsp_strobe        (rsp_strobe),
      .rsp_heading_error (rsp_heading_error),
      .rsp_arrived       (rsp_arrived)
   );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for waypoint_bearing_error_core: a directed table, then random poses.
// Each accepted request is checked against the response, expected values from the table or a CORDIC predictor.
// Depends on wbe_pkg and the RTL of the core.
`timescale 1ns / 1ps

module tb;
   import wbe_pkg::*;

   localparam int STEPS       = 16;
   localparam int LATENCY     = STEPS + 4;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_POSES = 800;

   localparam logic signed [POS_W-1:0] POS_MIN  = 32'sh8000_0000;
   localparam logic signed [POS_W-1:0] POS_MAX  = 32'sh7FFF_FFFF;
   localparam logic [PROX_W-1:0]       PROX_MAX = 31'h7FFF_FFFF;

   typedef struct {
      logic signed [POS_W-1:0]     rx;
      logic signed [POS_W-1:0]     ry;
      logic        [HEADING_W-1:0] hdg;
      logic signed [POS_W-1:0]     tx;
      logic signed [POS_W-1:0]     ty;
      logic        [PROX_W-1:0]    prox;
   } waypoint_req_type;

   typedef struct {
      logic [HEADING_W-1:0] heading_error;
      logic                 arrived;
   } steer_type;

   typedef struct {
      waypoint_req_type req;
      bit               typed;
      steer_type        want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic signed [POS_W-1:0]     req_robot_x;
   logic signed [POS_W-1:0]     req_robot_y;
   logic        [HEADING_W-1:0] req_robot_heading;
   logic signed [POS_W-1:0]     req_target_x;
   logic signed [POS_W-1:0]     req_target_y;
   logic        [PROX_W-1:0]    req_proximity;
   logic                        rsp_strobe;
   logic        [HEADING_W-1:0] rsp_heading_error;
   logic                        rsp_arrived;

   steer_type    expected_steer[$];
   stim_row_type stim_table[$];
   steer_type    oldest_steer;
   int           errors = 0;
   int           stall_cycles = 0;
   int           burst_left = 0;

   waypoint_bearing_error_core #(.CORDIC_STEPS(STEPS)) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_robot_x       (req_robot_x),
      .req_robot_y       (req_robot_y),
      .req_robot_heading (req_robot_heading),
      .req_target_x      (req_target_x),
      .req_target_y      (req_target_y),
      .req_proximity     (req_proximity),
      .rsp_strobe        (rsp_strobe),
      .rsp_heading_error (rsp_heading_error),
      .rsp_arrived       (rsp_arrived)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Turn needed to face the waypoint, and whether it counts as reached.
   function automatic steer_type steer_toward(input waypoint_req_type r);
      longint      dx, dy, adx, ady, cx, cy, xs, ys, limit;
      logic [31:0] z, neg, rounded;
      logic [HEADING_W-1:0] bearing;
      int          steps;
      steer_type   s;
      dx = longint'(r.tx) - longint'(r.rx);
      dy = longint'(r.ty) - longint'(r.ry);
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      if (dx == 0) begin
         if (dy > 0) bearing = BEARING_DY_POS;
         else if (dy == 0) bearing = BEARING_DY_ZERO;
         else bearing = BEARING_DY_NEG;
      end else begin
         steps = (STEPS > MAX_STEPS) ? MAX_STEPS : STEPS;
         cx = dy <<< PRESCALE_SH;
         cy = dx <<< PRESCALE_SH;
         z = 32'd0;
         // Vectors pointing backward are turned by half a turn first.
         if (cx < 0) begin
            cx = -cx;
            cy = -cy;
            z = HALF_TURN;
         end
         for (int i = 0; i < steps; i++) begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (cy > 0) begin
               cx = cx + ys;
               cy = cy - xs;
               z = z + ATAN_TURNS[i];
            end else begin
               cx = cx - ys;
               cy = cy + xs;
               z = z - ATAN_TURNS[i];
            end
         end
         neg = 32'd0 - z;
         rounded = neg + 32'h0000_8000;
         bearing = rounded[31:16];
      end
      limit = longint'(r.prox);
      s.heading_error = bearing - r.hdg;
      s.arrived = (adx < limit) && (ady < limit);
      return s;
   endfunction

   function automatic logic signed [POS_W-1:0] edge_value();
      case ($urandom_range(0, 4))
         0: return POS_MIN;
         1: return POS_MAX;
         2: return 32'sd0;
         3: return -32'sd1;
         default: return 32'sd1;
      endcase
   endfunction

   function automatic waypoint_req_type random_pose();
      waypoint_req_type r;
      logic signed [POS_W-1:0] off_x, off_y;
      int sh;
      r.rx = $urandom;
      r.ry = $urandom;
      r.hdg = HEADING_W'($urandom);
      r.tx = $urandom;
      r.ty = $urandom;
      r.prox = PROX_W'($urandom);
      sh = $urandom_range(0, 31);
      off_x = $signed($urandom) >>> sh;
      off_y = $signed($urandom) >>> $urandom_range(0, 31);
      case ($urandom_range(0, 9))
         // Waypoint near the robot, threshold on a similar scale.
         3, 4, 5: begin
            r.tx = r.rx + off_x;
            r.ty = r.ry + off_y;
            r.prox = PROX_W'($urandom >> sh);
         end
         6: begin
            r.tx = r.rx;
            if ($urandom_range(0, 2) == 0) r.ty = r.ry;
            else r.ty = r.ry + off_y;
         end
         7: begin
            r.ty = r.ry;
            r.tx = r.rx + off_x;
         end
         8: begin
            r.rx = edge_value();
            r.ry = edge_value();
            r.tx = edge_value();
            r.ty = edge_value();
            case ($urandom_range(0, 3))
               0: r.prox = '0;
               1: r.prox = 31'd1;
               2: r.prox = PROX_MAX;
               default: r.prox = PROX_W'($urandom);
            endcase
         end
         9: begin
            r.tx = r.rx + int'($urandom_range(0, 6)) - 3;
            r.ty = r.ry + int'($urandom_range(0, 6)) - 3;
            r.prox = PROX_W'($urandom_range(0, 4));
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic add_row(input logic signed [POS_W-1:0] rx, input logic signed [POS_W-1:0] ry,
                          input logic [HEADING_W-1:0] hdg, input logic signed [POS_W-1:0] tx,
                          input logic signed [POS_W-1:0] ty, input logic [PROX_W-1:0] prox,
                          input bit typed, input logic [HEADING_W-1:0] want_err = '0,
                          input logic want_arr = 1'b0);
      stim_row_type row;
      row.req.rx = rx;
      row.req.ry = ry;
      row.req.hdg = hdg;
      row.req.tx = tx;
      row.req.ty = ty;
      row.req.prox = prox;
      row.typed = typed;
      row.want.heading_error = want_err;
      row.want.arrived = want_arr;
      stim_table = {stim_table, row};
   endtask

   // Bursts of random length, most of them separated by short random gaps.
   task automatic pace();
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         if ($urandom_range(0, 3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic send(input waypoint_req_type r, input steer_type want);
      start <= 1'b1;
      req_robot_x <= r.rx;
      req_robot_y <= r.ry;
      req_robot_heading <= r.hdg;
      req_target_x <= r.tx;
      req_target_y <= r.ty;
      req_proximity <= r.prox;
      do @(posedge clock); while (busy);
      expected_steer = {expected_steer, want};
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_steer.size() == 0) begin
            $error("unexpected response: heading_error %0d arrived %0d",
                   rsp_heading_error, rsp_arrived);
            errors++;
         end else begin
            oldest_steer = expected_steer.pop_front();
            if (rsp_heading_error !== oldest_steer.heading_error) begin
               $error("heading_error: expected %0d, actual %0d",
                      oldest_steer.heading_error, rsp_heading_error);
               errors++;
            end
            if (rsp_arrived !== oldest_steer.arrived) begin
               $error("arrived: expected %0d, actual %0d", oldest_steer.arrived, rsp_arrived);
               errors++;
            end
         end
      end
   end

   // Ends the run if neither a request nor a response transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == STALL_LIMIT) begin
            $display("tb: errors");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_robot_x = '0;
      req_robot_y = '0;
      req_robot_heading = '0;
      req_target_x = '0;
      req_target_y = '0;
      req_proximity = '0;

      // Coincident positions, and waypoints straight ahead or straight behind.
      add_row(0, 0, 16'h0000, 0, 0, 0, 1, 16'hC000, 1'b0);
      add_row(0, 0, 16'h0000, 0, 0, 1, 1, 16'hC000, 1'b1);
      add_row(100, 0, 16'h0000, 100, 5, 0, 1, 16'hFFFF, 1'b0);
      add_row(100, 0, 16'hFFFF, 100, 5, 0, 1, 16'h0000, 1'b0);
      add_row(100, 0, 16'h0000, 100, -5, 0, 1, 16'h8000, 1'b0);
      add_row(100, 0, 16'h8000, 100, -5, 10, 1, 16'h0000, 1'b1);
      add_row(-7, -7, 16'hC000, -7, -7, PROX_MAX, 1, 16'h0000, 1'b1);
      // Largest position differences.
      add_row(POS_MIN, 0, 16'h0000, POS_MAX, 0, PROX_MAX, 0);
      add_row(POS_MAX, 0, 16'h0000, POS_MIN, 0, PROX_MAX, 0);
      add_row(0, POS_MIN, 16'h0000, 1, POS_MAX, PROX_MAX, 0);
      add_row(0, POS_MAX, 16'h0000, -1, POS_MIN, PROX_MAX, 0);
      add_row(POS_MIN, POS_MIN, 16'h1234, POS_MAX, POS_MAX, 0, 0);
      add_row(POS_MAX, POS_MAX, 16'hFFFF, POS_MIN, POS_MIN, 0, 0);
      // One waypoint per quadrant; the backward ones take the half-turn path.
      add_row(0, 0, 16'h0000, 1000, 1000, 0, 0);
      add_row(0, 0, 16'h0000, -1000, 1000, 0, 0);
      add_row(0, 0, 16'h0000, 1000, -1000, 0, 0);
      add_row(0, 0, 16'h0000, -1000, -1000, 0, 0);
      add_row(0, 0, 16'h0000, 1, 0, 0, 0);
      add_row(0, 0, 16'h0000, -1, 0, 0, 0);
      add_row(0, 0, 16'h0000, 1, -1, 2, 0);
      // Arrival threshold is strict on each axis.
      add_row(0, 0, 16'h0000, 50, -49, 50, 0);
      add_row(0, 0, 16'h0000, 49, -49, 50, 0);
      add_row(0, 0, 16'h5A5A, 32'sh7FFF_FFFE, 0, PROX_MAX, 0);
      add_row(-1, 0, 16'h0000, POS_MAX, 1, PROX_MAX, 0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         pace();
         send(stim_table[i].req,
              stim_table[i].typed ? stim_table[i].want : steer_toward(stim_table[i].req));
      end

      for (int n = 0; n < RANDOM_POSES; n++) begin
         waypoint_req_type pose;
         pose = random_pose();
         pace();
         send(pose, steer_toward(pose));
      end
      start <= 1'b0;

      while (expected_steer.size() != 0) @(posedge clock);
      // Give any stray response time to show up.
      repeat (LATENCY + 8) @(posedge clock);

      if (errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/wbe_pkg.sv
rtl/wbe_front.sv
rtl/wbe_cordic_stage.sv
rtl/wbe_back.sv
rtl/waypoint_bearing_error_core.sv
tb/tb.sv
